>>> sv/sraw_pkg.sv
// ----------------------------------------------------------------------------
// sraw_pkg: shared types and constants of the selective-repeat ack window
// Widths, sequencer states and the control/status bundles between the
// sequencer and the window core.
// ----------------------------------------------------------------------------
`default_nettype none

package sraw_pkg;

    localparam int SEQ_W     = 8;    // sequence space of 256 numbers
    localparam int MAP_W     = 64;   // largest window, one bit per offset
    localparam int IDX_W     = 6;    // bit index into the bitmap
    localparam int WIDTH_W   = 7;    // window width register
    localparam int CNT_W     = 7;    // scan count, holds up to MAP_W
    localparam int OUT_DATA_W = 24;  // result item, padded to whole bytes

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(16);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAP_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } sraw_state_t;

    // Decision taken for an item at acceptance.
    typedef struct packed {
        logic             base_ack;
        logic             set_req;
        logic [IDX_W-1:0] set_idx;
    } item_dec_t;

    // Commands from the sequencer to the window core.
    typedef struct packed {
        logic             start_scan;
        logic             step;
        logic             set_bit;
        logic [IDX_W-1:0] set_idx;
    } core_ctrl_t;

    // Status from the window core back to the sequencer.
    typedef struct packed {
        logic             low_bit;
        logic [CNT_W-1:0] cnt;
    } core_stat_t;

endpackage

`default_nettype wire

>>> sv/sraw_core.sv
// ----------------------------------------------------------------------------
// sraw_core: window base, ack bitmap and the one-bit shift unit
// Each step shifts the bitmap down by one offset and advances the base by
// one.
// ----------------------------------------------------------------------------
`default_nettype none

module sraw_core
    import sraw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire core_ctrl_t       ctrl,
    output logic [MAP_W-1:0]      bitmap,
    output logic [SEQ_W-1:0]      base,
    output core_stat_t            stat
);

    logic [MAP_W-1:0] bitmap_reg;
    logic [MAP_W-1:0] bitmap_next;
    logic [SEQ_W-1:0] base_reg;
    logic [SEQ_W-1:0] base_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        bitmap_next = bitmap_reg;
        base_next   = base_reg;
        cnt_next    = cnt_reg;
        if (ctrl.set_bit)
        begin
            bitmap_next[ctrl.set_idx] = 1'b1;
        end
        if (ctrl.start_scan || ctrl.step)
        begin
            bitmap_next = {1'b0, bitmap_reg[MAP_W-1:1]};
            base_next   = base_reg + SEQ_W'(1);
            cnt_next    = ctrl.start_scan ? CNT_W'(1) : cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_reg <= '0;
            base_reg   <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            bitmap_reg <= bitmap_next;
            base_reg   <= base_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign bitmap       = bitmap_reg;
    assign base         = base_reg;
    assign stat.low_bit = bitmap_reg[0];
    assign stat.cnt     = cnt_reg;

endmodule

`default_nettype wire

>>> sv/sraw_ctrl.sv
// ----------------------------------------------------------------------------
// sraw_ctrl: sequencer of the ack window
// Accepts an item when idle, drives the shift unit through a slide and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sraw_ctrl
    import sraw_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire item_dec_t          dec,
    input  wire logic [WIDTH_W-1:0] width,
    input  wire core_stat_t         stat,
    input  wire logic               out_free,
    output logic                    in_ready,
    output core_ctrl_t              ctrl,
    output logic                    load_out
);

    sraw_state_t state_reg;
    sraw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        load_out        = 1'b0;
        ctrl.start_scan = 1'b0;
        ctrl.step       = 1'b0;
        ctrl.set_bit    = 1'b0;
        ctrl.set_idx    = dec.set_idx;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (dec.base_ack)
                    begin
                        ctrl.start_scan = 1'b1;
                        state_next      = ST_SCAN;
                    end
                    else
                    begin
                        ctrl.set_bit = dec.set_req;
                        state_next   = ST_EMIT;
                    end
                end
            end
            ST_SCAN:
            begin
                // The offset now at bit 0 is the next one after the slide so far.
                if ((stat.cnt < width) && stat.low_bit)
                begin
                    ctrl.step = 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/selective_repeat_ack_window_top.sv
// ----------------------------------------------------------------------------
// selective_repeat_ack_window_top: selective-repeat send window tracker
// Classifies each item against the window and slides the window on an
// acknowledgement of the base.
// ----------------------------------------------------------------------------
// An item that slides the window by s offsets (s up to 64) passes through the
// scan state, where the one-bit shift unit steps once per cycle; every item
// then waits in the emit state until the output register is free.
// The next item is taken once the result has moved to the output register.
// Reset: base 0, bitmap cleared, window width 16, no result pending.
`default_nettype none

module selective_repeat_ack_window_top
    import sraw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [WIDTH_W-1:0]    cfg_wr_data,   // window_width
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [SEQ_W-1:0]      s_tdata,       // seq_num
    input  wire logic                  s_tuser,       // cmd
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // is_acked, inside_window, inside_prewindow, offset[7:0], new_base[7:0]
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic [WIDTH_W-1:0] width_reg;
    logic [WIDTH_W-1:0] eff_width;

    logic [MAP_W-1:0]   bitmap;
    logic [SEQ_W-1:0]   base;
    core_stat_t         stat;
    core_ctrl_t         ctrl;
    item_dec_t          dec;
    logic               load_out;
    logic               accept;

    logic [SEQ_W-1:0]   off;
    logic [SEQ_W-1:0]   back;
    logic               inwin;
    logic               inpre;
    logic               acked;

    logic               acked_reg;
    logic               inwin_reg;
    logic               inpre_reg;
    logic [SEQ_W-1:0]   off_reg;

    logic               m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            width_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_width = WIDTH_W'(1);
        end
        else if (width_reg > WIDTH_MAX)
        begin
            eff_width = WIDTH_MAX;
        end
        else
        begin
            eff_width = width_reg;
        end
    end

    // Classification against the state before any update.
    assign off   = s_tdata - base;
    assign back  = base - s_tdata;
    assign inwin = off < {1'b0, eff_width};
    assign inpre = (back != '0) && (back <= {1'b0, eff_width});
    assign acked = inwin ? bitmap[off[IDX_W-1:0]] : 1'b1;

    assign dec.base_ack = !s_tuser && (off == '0);
    assign dec.set_req  = !s_tuser && inwin;
    assign dec.set_idx  = off[IDX_W-1:0];

    assign accept = s_tvalid && s_tready;

    sraw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .dec      (dec),
        .width    (eff_width),
        .stat     (stat),
        .out_free (!m_tvalid_reg || m_tready),
        .in_ready (s_tready),
        .ctrl     (ctrl),
        .load_out (load_out)
    );

    sraw_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .bitmap (bitmap),
        .base   (base),
        .stat   (stat)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            acked_reg <= acked;
            inwin_reg <= inwin;
            inpre_reg <= inpre;
            off_reg   <= off;
        end
        if (load_out)
        begin
            m_tdata_reg <= {(OUT_DATA_W - 3 - 2 * SEQ_W)'(0), base, off_reg,
                            inpre_reg, inwin_reg, acked_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for selective_repeat_ack_window_top
// A directed table runs first: window edges, the pre-window, base slides,
// a slide by the full width and clamped widths. Random phases follow. Each
// phase sets a new window width and mixes well-formed acknowledgement
// traffic around the current base with queries and noise. Every result is
// compared field by field against a table literal or a window tracker in the bench.
// ----------------------------------------------------------------------------

module testbench;
    import sraw_pkg::*;

    localparam logic CMD_ACK   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam int   N_PHASES  = 20;
    localparam int   PHASE_LEN = 60;
    localparam int   DRAIN_CYC = 80;   // covers the longest slide of 64 offsets

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_RARE_STALL,
        RDY_PATTERN
    } rdy_mode_t;

    typedef struct packed {
        logic       acked;
        logic       in_win;
        logic       in_pre;
        logic [7:0] off;
        logic [7:0] nbase;
    } window_res_t;

    typedef struct packed {
        bit                 is_cfg;
        logic [WIDTH_W-1:0] cfg_val;
        logic               cmd;
        logic [SEQ_W-1:0]   seq;
        bit                 lit;
        window_res_t        exp;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [WIDTH_W-1:0]    cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SEQ_W-1:0]      s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Window tracker state.
    logic [WIDTH_W-1:0] width_reg = WIDTH_RESET;
    logic [SEQ_W-1:0]   win_base  = '0;
    logic [MAP_W-1:0]   ack_map   = '0;

    window_res_t expected_q [$];
    window_res_t want;
    int          err_count  = 0;
    int          burst_left = 0;
    bit          steady     = 1'b0;

    rdy_mode_t   rdy_mode  = RDY_ALWAYS;
    int          rdy_left  = 0;
    logic [7:0]  rdy_pat   = 8'hFF;
    logic [2:0]  rdy_ph    = '0;

    logic [WIDTH_W-1:0] phase_widths [9] = '{7'd1, 7'd2, 7'd63, 7'd64, 7'd65,
                                             7'd0, 7'd16, 7'd127, 7'd32};

    // Columns: is_cfg, cfg_val, cmd, seq, lit, {acked, in_win, in_pre, off, nbase}
    dir_row_t dir_tab [31] = '{
        '{1'b0, 7'd0,   CMD_QUERY, 8'd0,   1'b1, '{1'b0, 1'b1, 1'b0, 8'd0,   8'd0}},
        '{1'b0, 7'd0,   CMD_QUERY, 8'd255, 1'b1, '{1'b1, 1'b0, 1'b1, 8'd255, 8'd0}},
        '{1'b0, 7'd0,   CMD_QUERY, 8'd16,  1'b1, '{1'b1, 1'b0, 1'b0, 8'd16,  8'd0}},
        '{1'b0, 7'd0,   CMD_QUERY, 8'd15,  1'b1, '{1'b0, 1'b1, 1'b0, 8'd15,  8'd0}},
        '{1'b0, 7'd0,   CMD_QUERY, 8'd240, 1'b1, '{1'b1, 1'b0, 1'b1, 8'd240, 8'd0}},
        '{1'b0, 7'd0,   CMD_QUERY, 8'd239, 1'b1, '{1'b1, 1'b0, 1'b0, 8'd239, 8'd0}},
        '{1'b0, 7'd0,   CMD_ACK,   8'd5,   1'b1, '{1'b0, 1'b1, 1'b0, 8'd5,   8'd0}},
        '{1'b0, 7'd0,   CMD_QUERY, 8'd5,   1'b1, '{1'b1, 1'b1, 1'b0, 8'd5,   8'd0}},
        '{1'b0, 7'd0,   CMD_ACK,   8'd200, 1'b1, '{1'b1, 1'b0, 1'b0, 8'd200, 8'd0}},
        '{1'b0, 7'd0,   CMD_ACK,   8'd1,   1'b0, '0},
        '{1'b0, 7'd0,   CMD_ACK,   8'd2,   1'b0, '0},
        '{1'b0, 7'd0,   CMD_ACK,   8'd3,   1'b0, '0},
        '{1'b0, 7'd0,   CMD_ACK,   8'd4,   1'b0, '0},
        '{1'b0, 7'd0,   CMD_ACK,   8'd0,   1'b1, '{1'b0, 1'b1, 1'b0, 8'd0,   8'd6}},
        '{1'b0, 7'd0,   CMD_ACK,   8'd6,   1'b0, '0},
        '{1'b1, 7'd4,   CMD_QUERY, 8'd0,   1'b0, '0},
        '{1'b0, 7'd0,   CMD_ACK,   8'd8,   1'b0, '0},
        '{1'b0, 7'd0,   CMD_ACK,   8'd9,   1'b0, '0},
        '{1'b0, 7'd0,   CMD_ACK,   8'd10,  1'b0, '0},
        '{1'b0, 7'd0,   CMD_ACK,   8'd7,   1'b1, '{1'b0, 1'b1, 1'b0, 8'd0,   8'd11}},
        '{1'b1, 7'd0,   CMD_QUERY, 8'd0,   1'b0, '0},
        '{1'b0, 7'd0,   CMD_QUERY, 8'd11,  1'b1, '{1'b0, 1'b1, 1'b0, 8'd0,   8'd11}},
        '{1'b0, 7'd0,   CMD_ACK,   8'd12,  1'b1, '{1'b1, 1'b0, 1'b0, 8'd1,   8'd11}},
        '{1'b0, 7'd0,   CMD_ACK,   8'd11,  1'b1, '{1'b0, 1'b1, 1'b0, 8'd0,   8'd12}},
        '{1'b1, 7'd127, CMD_QUERY, 8'd0,   1'b0, '0},
        '{1'b0, 7'd0,   CMD_QUERY, 8'd75,  1'b0, '0},
        '{1'b0, 7'd0,   CMD_QUERY, 8'd76,  1'b0, '0},
        '{1'b0, 7'd0,   CMD_QUERY, 8'd204, 1'b0, '0},
        '{1'b0, 7'd0,   CMD_ACK,   8'd75,  1'b0, '0},
        '{1'b0, 7'd0,   CMD_QUERY, 8'd75,  1'b0, '0},
        '{1'b1, 7'd64,  CMD_QUERY, 8'd0,   1'b0, '0}
    };

    selective_repeat_ack_window_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] r);
        if (r == '0)
            return 7'd1;
        if (r > WIDTH_MAX)
            return WIDTH_MAX;
        return r;
    endfunction

    // Classifies one item against the window, then applies its update.
    task automatic track_window(input logic cmd, input logic [SEQ_W-1:0] seq,
                                output window_res_t r);
        logic [WIDTH_W-1:0] w;
        logic [SEQ_W-1:0]   off;
        logic [SEQ_W-1:0]   back;
        int                 s;
        w    = eff_width(width_reg);
        off  = seq - win_base;
        back = win_base - seq;
        r.in_win = (off < {1'b0, w});
        r.in_pre = (back != '0) && (back <= {1'b0, w});
        r.acked  = r.in_win ? ack_map[off[IDX_W-1:0]] : 1'b1;
        r.off    = off;
        if (cmd == CMD_ACK)
        begin
            if (seq == win_base)
            begin
                // Slide past the run of acknowledged offsets after the base, within the window.
                s = 1;
                while (s < int'(w) && ack_map[s])
                    s++;
                if (s >= MAP_W)
                    ack_map = '0;
                else
                    ack_map = ack_map >> s;
                win_base = win_base + SEQ_W'(s);
            end
            else if (r.in_win)
            begin
                ack_map[off[IDX_W-1:0]] = 1'b1;
            end
        end
        r.nbase = win_base;
    endtask

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int exp);
        if (got != exp)
            flag_error($sformatf("%s: got %0d, expected %0d", name, got, exp));
    endtask

    task automatic send_item(input logic cmd, input logic [SEQ_W-1:0] seq,
                             input bit use_lit, input window_res_t lit);
        int          gap;
        window_res_t res;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= seq;
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        track_window(cmd, seq, res);
        expected_q.push_back(use_lit ? lit : res);
        burst_left--;
    endtask

    task automatic wait_idle(input int extra);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_width(input logic [WIDTH_W-1:0] val);
        wait_idle(4);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        width_reg  = val;
        burst_left = 0;
    endtask

    // Acknowledges every offset after the base in shuffled order, then the
    // base, so that the slide runs across the whole width.
    task automatic fill_and_slide();
        int         ofs [MAP_W];
        int         n;
        int         j;
        int         t;
        logic [SEQ_W-1:0] base0;
        n     = int'(eff_width(width_reg)) - 1;
        base0 = win_base;
        for (int i = 0; i < n; i++)
            ofs[i] = i + 1;
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = ofs[i];
            ofs[i] = ofs[j];
            ofs[j] = t;
        end
        for (int i = 0; i < n; i++)
            send_item(CMD_ACK, base0 + SEQ_W'(ofs[i]), 1'b0, '0);
        send_item(CMD_ACK, base0, 1'b0, '0);
    endtask

    task automatic random_item();
        int   r;
        int   wv;
        int   k;
        logic cmd;
        r   = $urandom_range(0, 99);
        wv  = int'(eff_width(width_reg));
        cmd = CMD_ACK;
        if (r < 40)
            k = $urandom_range(1, (wv > 1) ? wv - 1 : 1);
        else if (r < 55)
            k = 0;
        else if (r < 70)
        begin
            cmd = CMD_QUERY;
            k   = $urandom_range(0, wv - 1);
        end
        else if (r < 78)
        begin
            cmd = 1'($urandom_range(0, 1));
            k   = -int'($urandom_range(1, wv));
        end
        else if (r < 88)
        begin
            // Just inside and just outside the window's upper edge and the pre-window's lower edge, or the base.
            cmd = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 4))
                0: k = wv - 1;
                1: k = wv;
                2: k = -wv;
                3: k = -wv - 1;
                default: k = 0;
            endcase
        end
        else
        begin
            cmd = 1'($urandom_range(0, 1));
            k   = $urandom_range(0, 255);
        end
        send_item(cmd, SEQ_W'(int'(win_base) + k), 1'b0, '0);
    endtask

    // Receiver stalls follow a mode that is redrawn at random when its run ends.
    always @(negedge clk)
    begin
        if (rdy_left == 0)
        begin
            rdy_mode = rdy_mode_t'($urandom_range(0, 3));
            rdy_left = $urandom_range(20, 300);
            rdy_pat  = 8'($urandom_range(0, 255)) | 8'h01;
        end
        rdy_left--;
        rdy_ph++;
        case (rdy_mode)
            RDY_ALWAYS:     m_tready <= 1'b1;
            RDY_COIN:       m_tready <= 1'($urandom_range(0, 1));
            RDY_RARE_STALL: m_tready <= ($urandom_range(0, 7) != 0);
            default:        m_tready <= rdy_pat[rdy_ph];
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                flag_error($sformatf("result with none expected, data %h", m_tdata));
            end
            else
            begin
                want = expected_q.pop_front();
                compare_field("is_acked", m_tdata[0], want.acked);
                compare_field("inside_window", m_tdata[1], want.in_win);
                compare_field("inside_prewindow", m_tdata[2], want.in_pre);
                compare_field("offset", m_tdata[10:3], want.off);
                compare_field("new_base", m_tdata[18:11], want.nbase);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [WIDTH_W-1:0] wsel;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_QUERY;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
                write_width(dir_tab[i].cfg_val);
            else
                send_item(dir_tab[i].cmd, dir_tab[i].seq, dir_tab[i].lit, dir_tab[i].exp);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            wsel = (p < 9) ? phase_widths[p] : WIDTH_W'($urandom_range(0, 127));
            write_width(wsel);
            steady = ($urandom_range(0, 3) == 0);
            if (p % 3 == 0 || p == 4)
                fill_and_slide();
            for (int i = 0; i < PHASE_LEN; i++)
                random_item();
        end

        wait_idle(DRAIN_CYC);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> selective_repeat_ack_window_top.f
sv/sraw_pkg.sv
sv/sraw_core.sv
sv/sraw_ctrl.sv
sv/selective_repeat_ack_window_top.sv
sim/testbench.sv
